// ----- rtl/core/asc_cdl_color_grade_macros.svh -----
// Assertion macros shared by the color grade RTL.
// Included by asc_cdl_color_grade.sv; needs no package.
`ifndef ASC_CDL_COLOR_GRADE_MACROS_SVH
`define ASC_CDL_COLOR_GRADE_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Plain invariant, checked on the rising clock edge outside reset.
`define ASC_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// ----- rtl/core/asc_cdl_pkg.sv -----
// Package for the ASC CDL color grade: fixed-point widths, codes and the
// log2 / exp2 lookup tables built at elaboration. No dependencies.
`timescale 1ns / 1ps

package asc_cdl_pkg;

    localparam int LOG_TABLE_BITS = 8;
    localparam int EXP_TABLE_BITS = 8;
    localparam int LOG_N          = 1 << LOG_TABLE_BITS;
    localparam int EXP_N          = 1 << EXP_TABLE_BITS;
    localparam int LOG_SHIFT      = 19 - LOG_TABLE_BITS;
    localparam int EXP_SHIFT      = 28 - EXP_TABLE_BITS;

    // Pipeline stages between an accepted start and the result strobe.
    localparam int PIPE_DEPTH     = 9;

    localparam int CFG_W          = 48;
    localparam logic [CFG_W-1:0] SLOPE_RESET  = 48'h1000_1000_1000;
    localparam logic [CFG_W-1:0] OFFSET_RESET = 48'h0;
    localparam logic [CFG_W-1:0] POWER_RESET  = 48'h1000_1000_1000;

    localparam logic [12:0] OUT_ONE = 13'd4096;

    typedef enum logic [1:0] {
        CFG_SLOPE  = 2'd0,
        CFG_OFFSET = 2'd1,
        CFG_POWER  = 2'd2
    } t_cfg_idx;

    // Result forced by a special case, decided as early as it is known.
    typedef enum logic [1:0] {
        FRC_NONE = 2'd0,
        FRC_ZERO = 2'd1,
        FRC_ONE  = 2'd2
    } t_force;

    typedef logic [16:0] t_log_tab [0:LOG_N];
    typedef logic [30:0] t_exp_tab [0:EXP_N];

    // log2(1 + i/N) in Q.16 by repeated squaring of a Q.30 mantissa.
    function automatic t_log_tab build_log_tab();
        t_log_tab        tab;
        longint unsigned x;
        longint unsigned y;
        for (int i = 0; i < LOG_N; i++) begin
            x = (64'd1 << 30) + (longint'(i) << (30 - LOG_TABLE_BITS));
            y = 0;
            for (int k = 1; k <= 16; k++) begin
                x = (x * x) >> 30;
                if (x >= (64'd2 << 30)) begin
                    x = x >> 1;
                    y = y | (64'd1 << (16 - k));
                end
            end
            tab[i] = 17'(y);
        end
        tab[LOG_N] = 17'd65536;
        return tab;
    endfunction

    function automatic longint unsigned isqrt64(longint unsigned a);
        longint unsigned x;
        longint unsigned res;
        longint unsigned bt;
        x   = a;
        res = 0;
        bt  = 64'd1 << 62;
        while (bt > x) bt = bt >> 2;
        while (bt != 0) begin
            if (x >= res + bt) begin
                x   = x - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // 2^(-j/M) in Q.30 from products of repeated square roots of two.
    function automatic t_exp_tab build_exp_tab();
        t_exp_tab        tab;
        longint unsigned roots [0:EXP_TABLE_BITS];
        longint unsigned p;
        int              kk;
        roots[0] = 64'd2 << 30;
        for (int k = 1; k <= EXP_TABLE_BITS; k++) begin
            roots[k] = isqrt64(roots[k-1] << 30);
        end
        for (int i = 0; i <= EXP_N; i++) begin
            kk = EXP_N - i;
            p  = 64'd1 << 30;
            if (kk == EXP_N) begin
                p = 64'd2 << 30;
            end else begin
                for (int k = 1; k <= EXP_TABLE_BITS; k++) begin
                    if (((kk >> (EXP_TABLE_BITS - k)) & 1) == 1) begin
                        p = (p * roots[k]) >> 30;
                    end
                end
            end
            tab[i] = 31'(p >> 1);
        end
        return tab;
    endfunction

    localparam t_log_tab LOG_TAB = build_log_tab();
    localparam t_exp_tab EXP_TAB = build_exp_tab();

endpackage

// ----- rtl/core/asc_cdl_color_grade.sv -----
// Top level of the ASC CDL slope/offset/power color grade.
// Depends on asc_cdl_pkg, asc_cdl_channel and asc_cdl_color_grade_macros.svh.
`timescale 1ns / 1ps

// Usage
// A pixel transaction is taken at every rising edge with start high and busy
// low. busy is always low: the three channel pipelines accept one pixel per
// clock with no gaps, so throughput is one pixel per cycle.
// As each pixel leaves, o_valid is high for one cycle with the graded red,
// green and blue samples and the copied end-of-frame flag. The nine stages
// are slope multiply, offset add, leading one search, log table read, log
// interpolation, power multiply, exp table read, exp interpolation and final
// rounding. The receiver cannot stall the block; every result must be taken
// in the cycle in which its strobe is high. Configuration is a plain write
// port: i_cfg_idx picks slope, offset or power, and a write to the unused
// index is dropped. The user must change registers only while no pixel is
// in flight; the block does not enforce it. Reset returns slope and power
// to 1.0 in every channel and offset to zero, and flushes the valid bits;
// pixels in flight are lost.

module asc_cdl_color_grade
    import asc_cdl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [15:0]       i_red_in,
    input  logic [15:0]       i_green_in,
    input  logic [15:0]       i_blue_in,
    input  logic              i_frame_end_in,
    output logic              o_valid,
    output logic [12:0]       o_red_out,
    output logic [12:0]       o_green_out,
    output logic [12:0]       o_blue_out,
    output logic              o_frame_end_out,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data
);

`include "asc_cdl_color_grade_macros.svh"

    logic [CFG_W-1:0] r_slope;
    logic [CFG_W-1:0] r_offset;
    logic [CFG_W-1:0] r_power;

    // Configuration writes; an index outside the list leaves everything as is.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slope  <= SLOPE_RESET;
            r_offset <= OFFSET_RESET;
            r_power  <= POWER_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SLOPE:  r_slope  <= i_cfg_data;
                CFG_OFFSET: r_offset <= i_cfg_data;
                CFG_POWER:  r_power  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The pipeline never holds off new pixels.
    assign busy = 1'b0;

    // Valid bits and the end-of-frame flag travel alongside the channel data.
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH-1:0] r_eof;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], start & ~busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_eof <= {r_eof[PIPE_DEPTH-2:0], i_frame_end_in};
    end

    asc_cdl_channel u_red (
        .i_clk    (i_clk),
        .i_sample (i_red_in),
        .i_slope  (r_slope[15:0]),
        .i_offset (r_offset[15:0]),
        .i_power  (r_power[15:0]),
        .o_graded (o_red_out)
    );

    asc_cdl_channel u_green (
        .i_clk    (i_clk),
        .i_sample (i_green_in),
        .i_slope  (r_slope[31:16]),
        .i_offset (r_offset[31:16]),
        .i_power  (r_power[31:16]),
        .o_graded (o_green_out)
    );

    asc_cdl_channel u_blue (
        .i_clk    (i_clk),
        .i_sample (i_blue_in),
        .i_slope  (r_slope[47:32]),
        .i_offset (r_offset[47:32]),
        .i_power  (r_power[47:32]),
        .o_graded (o_blue_out)
    );

    assign o_valid         = r_vld[PIPE_DEPTH-1];
    assign o_frame_end_out = r_eof[PIPE_DEPTH-1];

    // A result strobe only follows a pixel that was taken.
    `ASC_ASSERT_IMPL(a_valid_latency, i_clk, i_rst_n, o_valid, $past(start, PIPE_DEPTH), "result strobe without a matching start")
    // The flag leaves with the pixel it came in with.
    `ASC_ASSERT_IMPL(a_eof_aligned, i_clk, i_rst_n, o_valid, o_frame_end_out == $past(i_frame_end_in, PIPE_DEPTH), "end-of-frame flag out of step")
    // Graded samples never exceed 1.0.
    `ASC_ASSERT_IMPL(a_out_range, i_clk, i_rst_n, o_valid, (o_red_out <= OUT_ONE) && (o_green_out <= OUT_ONE) && (o_blue_out <= OUT_ONE), "graded sample above 1.0")
    // The block is never busy, so it can take a pixel in every cycle.
    `ASC_ASSERT_ALWAYS(a_never_busy, i_clk, i_rst_n, !busy, "busy raised")

endmodule

// ----- rtl/core/asc_cdl_channel.sv -----
// One color channel of the slope/offset/power grade as a nine-stage pipeline.
// Depends on asc_cdl_pkg for the lookup tables and the force codes.
`timescale 1ns / 1ps

module asc_cdl_channel
    import asc_cdl_pkg::*;
(
    input  logic        i_clk,
    input  logic [15:0] i_sample,
    input  logic [15:0] i_slope,
    input  logic [15:0] i_offset,
    input  logic [15:0] i_power,
    output logic [12:0] o_graded
);

    // Stage 1: clamp negative input and apply the slope.
    logic [30:0] r_s1_prod;
    logic [15:0] r_s1_off;
    logic [15:0] r_s1_pow;
    logic [14:0] n_s1_v;

    assign n_s1_v = i_sample[15] ? 15'd0 : i_sample[14:0];

    always_ff @(posedge i_clk) begin
        r_s1_prod <= 31'(n_s1_v * i_slope);
        r_s1_off  <= i_offset;
        r_s1_pow  <= i_power;
    end

    // Stage 2: add the offset, clamp the sum at zero and flag the forced results.
    logic signed [32:0] n_s2_sum;
    logic        [19:0] n_s2_base;
    logic        [19:0] r_s2_base;
    logic        [15:0] r_s2_pow;
    t_force             r_s2_frc;
    t_force             n_s2_frc;

    assign n_s2_sum  = $signed({2'b00, r_s1_prod})
                     + ($signed({{17{r_s1_off[15]}}, r_s1_off}) <<< 12);
    assign n_s2_base = (n_s2_sum > 0) ? n_s2_sum[31:12] : 20'd0;

    always_comb begin
        if (r_s1_pow == 16'd0) begin
            n_s2_frc = FRC_ONE;
        end else if (n_s2_base == 20'd0) begin
            n_s2_frc = FRC_ZERO;
        end else begin
            n_s2_frc = FRC_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_base <= n_s2_base;
        r_s2_pow  <= r_s1_pow;
        r_s2_frc  <= n_s2_frc;
    end

    // Stage 3: find the leading one and normalize the mantissa.
    logic [4:0]  n_s3_e;
    logic [19:0] n_s3_norm;
    logic [4:0]  r_s3_e;
    logic [18:0] r_s3_frac;
    logic [15:0] r_s3_pow;
    t_force      r_s3_frc;

    always_comb begin
        n_s3_e = 5'd0;
        for (int i = 0; i < 20; i++) begin
            if (r_s2_base[i]) begin
                n_s3_e = 5'(i);
            end
        end
    end

    assign n_s3_norm = r_s2_base << (5'd19 - n_s3_e);

    always_ff @(posedge i_clk) begin
        r_s3_e    <= n_s3_e;
        r_s3_frac <= n_s3_norm[18:0];
        r_s3_pow  <= r_s2_pow;
        r_s3_frc  <= r_s2_frc;
    end

    // Stage 4: log table lookup at the two neighboring entries.
    logic [LOG_TABLE_BITS-1:0] n_s4_idx;
    logic [LOG_TABLE_BITS:0]   n_s4_idx1;
    logic [16:0]               n_s4_lt0;
    logic [16:0]               n_s4_lt1;
    logic [16:0]               r_s4_lt0;
    logic [16:0]               r_s4_d;
    logic [LOG_SHIFT-1:0]      r_s4_rem;
    logic [4:0]                r_s4_e;
    logic [15:0]               r_s4_pow;
    t_force                    r_s4_frc;

    assign n_s4_idx  = r_s3_frac[18 -: LOG_TABLE_BITS];
    assign n_s4_idx1 = {1'b0, n_s4_idx} + 1'b1;
    assign n_s4_lt0  = LOG_TAB[{1'b0, n_s4_idx}];
    assign n_s4_lt1  = LOG_TAB[n_s4_idx1];

    always_ff @(posedge i_clk) begin
        r_s4_lt0 <= n_s4_lt0;
        r_s4_d   <= n_s4_lt1 - n_s4_lt0;
        r_s4_rem <= r_s3_frac[LOG_SHIFT-1:0];
        r_s4_e   <= r_s3_e;
        r_s4_pow <= r_s3_pow;
        r_s4_frc <= r_s3_frc;
    end

    // Stage 5: interpolate and add the exponent, giving log2 of the base in Q.16.
    logic        [17+LOG_SHIFT:0] n_s5_num;
    logic signed [5:0]            n_s5_exp;
    logic signed [21:0]           n_s5_lg;
    logic signed [21:0]           r_s5_lg;
    logic        [15:0]           r_s5_pow;
    t_force                       r_s5_frc;

    assign n_s5_num = ({1'b0, r_s4_lt0, {LOG_SHIFT{1'b0}}})
                    + (18 + LOG_SHIFT)'(r_s4_d * r_s4_rem);
    assign n_s5_exp = $signed({1'b0, r_s4_e}) - 6'sd12;
    assign n_s5_lg  = ($signed({{16{n_s5_exp[5]}}, n_s5_exp}) <<< 16)
                    + $signed({4'b0000, n_s5_num[17+LOG_SHIFT:LOG_SHIFT]});

    always_ff @(posedge i_clk) begin
        r_s5_lg  <= n_s5_lg;
        r_s5_pow <= r_s4_pow;
        r_s5_frc <= r_s4_frc;
    end

    // Stage 6: scale the logarithm by the power.
    logic signed [38:0] r_s6_t;
    t_force             r_s6_frc;

    always_ff @(posedge i_clk) begin
        r_s6_t   <= 39'(r_s5_lg * $signed({1'b0, r_s5_pow}));
        r_s6_frc <= r_s5_frc;
    end

    // Stage 7: split the negated product, look up the exp table and flag forced results.
    logic [37:0]               n_s7_y;
    logic [9:0]                n_s7_ip;
    logic [EXP_TABLE_BITS-1:0] n_s7_j;
    logic [EXP_TABLE_BITS:0]   n_s7_j1;
    logic [30:0]               n_s7_et0;
    logic [30:0]               n_s7_et1;
    t_force                    n_s7_frc;
    logic [30:0]               r_s7_et0;
    logic [30:0]               r_s7_d;
    logic [EXP_SHIFT-1:0]      r_s7_r;
    logic [3:0]                r_s7_ip;
    t_force                    r_s7_frc;

    assign n_s7_y   = 38'(-r_s6_t);
    assign n_s7_ip  = n_s7_y[37:28];
    assign n_s7_j   = n_s7_y[27 -: EXP_TABLE_BITS];
    assign n_s7_j1  = {1'b0, n_s7_j} + 1'b1;
    assign n_s7_et0 = EXP_TAB[{1'b0, n_s7_j}];
    assign n_s7_et1 = EXP_TAB[n_s7_j1];

    always_comb begin
        if (r_s6_frc != FRC_NONE) begin
            n_s7_frc = r_s6_frc;
        end else if (!r_s6_t[38]) begin
            n_s7_frc = FRC_ONE;
        end else if (n_s7_ip >= 10'd13) begin
            n_s7_frc = FRC_ZERO;
        end else begin
            n_s7_frc = FRC_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s7_et0 <= n_s7_et0;
        r_s7_d   <= n_s7_et0 - n_s7_et1;
        r_s7_r   <= n_s7_y[EXP_SHIFT-1:0];
        r_s7_ip  <= n_s7_ip[3:0];
        r_s7_frc <= n_s7_frc;
    end

    // Stage 8: interpolate between the two exp entries.
    logic [30+EXP_SHIFT:0] n_s8_num;
    logic [30:0]           r_s8_w;
    logic [3:0]            r_s8_ip;
    t_force                r_s8_frc;

    assign n_s8_num = {r_s7_et0, {EXP_SHIFT{1'b0}}}
                    - (31 + EXP_SHIFT)'(r_s7_d * r_s7_r);

    always_ff @(posedge i_clk) begin
        r_s8_w   <= n_s8_num[30+EXP_SHIFT:EXP_SHIFT];
        r_s8_ip  <= r_s7_ip;
        r_s8_frc <= r_s7_frc;
    end

    // Stage 9: round to Q.12 by the integer part, saturate, apply forced results.
    logic [43:0] n_s9_rnd;
    logic [43:0] n_s9_shf;
    logic [12:0] n_s9_out;
    logic [12:0] r_s9_out;

    assign n_s9_rnd = {1'b0, r_s8_w, 12'd0} + (44'd1 << (6'd29 + {2'b00, r_s8_ip}));
    assign n_s9_shf = n_s9_rnd >> (6'd30 + {2'b00, r_s8_ip});

    always_comb begin
        unique case (r_s8_frc)
            FRC_ZERO: n_s9_out = 13'd0;
            FRC_ONE:  n_s9_out = OUT_ONE;
            default: begin
                n_s9_out = (n_s9_shf > 44'(OUT_ONE)) ? OUT_ONE : n_s9_shf[12:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_s9_out <= n_s9_out;
    end

    assign o_graded = r_s9_out;

endmodule

// ----- test/asc_cdl_color_grade_checker.sv -----
// Scoreboard for the ASC CDL color grade: mirrors the configuration writes,
// predicts each graded pixel and compares it with the block's result strobe.
// Depends on asc_cdl_pkg for widths, register indexes and reset values.
`timescale 1ns / 1ps

module asc_cdl_color_grade_checker
    import asc_cdl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic [15:0]      i_red_in,
    input  logic [15:0]      i_green_in,
    input  logic [15:0]      i_blue_in,
    input  logic             i_frame_end_in,
    input  logic             o_valid,
    input  logic [12:0]      o_red_out,
    input  logic [12:0]      o_green_out,
    input  logic [12:0]      o_blue_out,
    input  logic             o_frame_end_out,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int               o_pending,
    output int               o_errors
);

    typedef struct packed {
        logic [12:0] red;
        logic [12:0] green;
        logic [12:0] blue;
        logic        frame_end;
    } t_graded_pixel;

    t_graded_pixel     graded_pixel_q [$];
    logic [CFG_W-1:0]  gain_regs;
    logic [CFG_W-1:0]  lift_regs;
    logic [CFG_W-1:0]  gamma_regs;
    longint unsigned   log2_lut [0:256];
    longint unsigned   exp2_lut [0:256];

    function automatic longint unsigned floor_sqrt(longint unsigned a);
        longint unsigned res;
        longint unsigned cand;
        res = 0;
        for (int b = 31; b >= 0; b--) begin
            cand = res | (64'd1 << b);
            if (cand * cand <= a) res = cand;
        end
        return res;
    endfunction

    // Both lookup tables are fixed; they are built once at time zero.
    initial begin
        longint unsigned x;
        longint unsigned y;
        longint unsigned p;
        longint unsigned roots [0:8];
        int              kk;
        for (int i = 0; i < 256; i++) begin
            x = (64'd1 << 30) + (longint'(i) << 22);
            y = 0;
            for (int k = 1; k <= 16; k++) begin
                x = (x * x) >> 30;
                if (x >= (64'd2 << 30)) begin
                    x = x >> 1;
                    y = y | (64'd1 << (16 - k));
                end
            end
            log2_lut[i] = y;
        end
        log2_lut[256] = 65536;
        roots[0] = 64'd2 << 30;
        for (int k = 1; k <= 8; k++) roots[k] = floor_sqrt(roots[k-1] << 30);
        for (int i = 0; i <= 256; i++) begin
            kk = 256 - i;
            if (kk == 256) begin
                p = 64'd2 << 30;
            end else begin
                p = 64'd1 << 30;
                for (int k = 1; k <= 8; k++)
                    if (kk[8-k]) p = (p * roots[k]) >> 30;
            end
            exp2_lut[i] = p >> 1;
        end
    end

    // One channel: clamp, slope, offset, then base^power through log2/exp2.
    function automatic logic [12:0] grade_sample(logic [15:0] smp, logic [15:0] slope,
                                                 logic [15:0] ofs, logic [15:0] pw);
        longint lin;
        longint lift;
        longint sum;
        longint base;
        longint frac;
        longint lg;
        longint t;
        longint y;
        longint ip;
        longint fr;
        longint j;
        longint r;
        longint num;
        longint w;
        longint res;
        int     e;
        lin  = smp[15] ? 0 : longint'(smp[14:0]);
        lift = $signed(ofs);
        sum  = lin * longint'(slope) + lift * 4096;
        if (pw == 0) return OUT_ONE;   // anything to the power zero is one
        base = (sum > 0) ? (sum >> 12) : 0;
        if (base == 0) return 13'd0;
        e = 19;
        while (e > 0 && base[e] == 1'b0) e--;
        frac = (base << (19 - e)) & 64'h7FFFF;
        j    = frac >> 11;
        r    = frac & 2047;
        num  = longint'(log2_lut[j]) * 2048
             + (longint'(log2_lut[j+1]) - longint'(log2_lut[j])) * r;
        lg   = longint'(e - 12) * 65536 + (num >> 11);
        t    = lg * longint'(pw);
        if (t >= 0) return OUT_ONE;    // base of one or more saturates
        y  = -t;
        ip = y >> 28;
        if (ip >= 13) return 13'd0;
        fr  = y & ((64'd1 << 28) - 1);
        j   = fr >> 20;
        r   = fr & ((64'd1 << 20) - 1);
        num = longint'(exp2_lut[j]) * (64'sd1 << 20)
            - (longint'(exp2_lut[j]) - longint'(exp2_lut[j+1])) * r;
        w   = num >> 20;
        res = ((w << 12) + (64'sd1 << (29 + ip))) >> (30 + ip);
        if (res > 4096) res = 4096;
        return 13'(res);
    endfunction

    always @(posedge i_clk) begin
        t_graded_pixel exp_px;
        if (!i_rst_n) begin
            gain_regs  = SLOPE_RESET;
            lift_regs  = OFFSET_RESET;
            gamma_regs = POWER_RESET;
            graded_pixel_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_SLOPE:  gain_regs  = i_cfg_data;
                    CFG_OFFSET: lift_regs  = i_cfg_data;
                    CFG_POWER:  gamma_regs = i_cfg_data;
                    default: ;  // unused index, write is dropped
                endcase
            end
            if (start && !busy) begin
                exp_px.red   = grade_sample(i_red_in, gain_regs[15:0], lift_regs[15:0],
                                            gamma_regs[15:0]);
                exp_px.green = grade_sample(i_green_in, gain_regs[31:16], lift_regs[31:16],
                                            gamma_regs[31:16]);
                exp_px.blue  = grade_sample(i_blue_in, gain_regs[47:32], lift_regs[47:32],
                                            gamma_regs[47:32]);
                exp_px.frame_end = i_frame_end_in;
                graded_pixel_q.push_back(exp_px);
            end
            if (o_valid) begin
                if (graded_pixel_q.size() == 0) begin
                    $display("%0t: unexpected result r=%0d g=%0d b=%0d fe=%0b", $time,
                             o_red_out, o_green_out, o_blue_out, o_frame_end_out);
                    o_errors++;
                end else begin
                    exp_px = graded_pixel_q.pop_front();
                    if (o_red_out !== exp_px.red) begin
                        $display("%0t: red expected %0d actual %0d", $time, exp_px.red,
                                 o_red_out);
                        o_errors++;
                    end
                    if (o_green_out !== exp_px.green) begin
                        $display("%0t: green expected %0d actual %0d", $time, exp_px.green,
                                 o_green_out);
                        o_errors++;
                    end
                    if (o_blue_out !== exp_px.blue) begin
                        $display("%0t: blue expected %0d actual %0d", $time, exp_px.blue,
                                 o_blue_out);
                        o_errors++;
                    end
                    if (o_frame_end_out !== exp_px.frame_end) begin
                        $display("%0t: frame_end expected %0b actual %0b", $time,
                                 exp_px.frame_end, o_frame_end_out);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = graded_pixel_q.size();
    end

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

endmodule

// ----- test/asc_cdl_color_grade_tb.sv -----
// Testbench top for the ASC CDL color grade: clock, reset, pixel and register
// stimulus, and the final verdict. Depends on asc_cdl_pkg, the block and
// asc_cdl_color_grade_checker.
`timescale 1ns / 1ps

module asc_cdl_color_grade_tb;
    import asc_cdl_pkg::*;

    // Index past the three registers; writes to it must be dropped.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [15:0]      i_red_in;
    logic [15:0]      i_green_in;
    logic [15:0]      i_blue_in;
    logic             i_frame_end_in;
    logic             o_valid;
    logic [12:0]      o_red_out;
    logic [12:0]      o_green_out;
    logic [12:0]      o_blue_out;
    logic             o_frame_end_out;
    logic             i_cfg_we;
    logic [1:0]       i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;
    int               pending;
    int               errors;

    asc_cdl_color_grade dut (.*);

    asc_cdl_color_grade_checker checker_i (
        .i_clk, .i_rst_n, .start, .busy, .i_red_in, .i_green_in, .i_blue_in,
        .i_frame_end_in, .o_valid, .o_red_out, .o_green_out, .o_blue_out,
        .o_frame_end_out, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_pending(pending), .o_errors(errors)
    );

    // 12 ns clock.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Runaway guard: far more than the slowest legal run needs.
    initial begin
        #6_000_000;
        $display("asc_cdl_color_grade test failed");
        $finish;
    end

    // Wait until every predicted pixel has come out, then let the pipeline
    // settle a little more. Called at a falling edge, returns at one.
    task automatic drain_pipe();
        while (pending != 0) @(negedge i_clk);
        repeat (PIPE_DEPTH + 2) @(negedge i_clk);
    endtask

    // One register write; the caller makes sure no pixel is in flight.
    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic write_all(logic [CFG_W-1:0] slope, logic [CFG_W-1:0] ofs,
                             logic [CFG_W-1:0] pw);
        write_reg(CFG_SLOPE, slope);
        write_reg(CFG_OFFSET, ofs);
        write_reg(CFG_POWER, pw);
    endtask

    // Present one pixel transaction and hold it until the block takes it.
    // Start stays high at the next falling edge if another pixel follows.
    task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b, logic fe);
        start          <= 1'b1;
        i_red_in       <= r;
        i_green_in     <= g;
        i_blue_in      <= b;
        i_frame_end_in <= fe;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // Idle cycles ahead of a pixel, each one taken with odds of 18 in a hundred.
    task automatic maybe_idle(bit allow);
        if (allow) begin
            while ($urandom_range(0, 99) < 18) begin
                start <= 1'b0;
                @(negedge i_clk);
            end
        end
    endtask

    // Mostly samples inside the useful 0..2.0 range, with negatives and raw
    // 16 bit patterns mixed in so every bit toggles.
    function automatic logic [15:0] rand_sample();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return 16'($urandom_range(0, 8192));
        if (sel == 6) return 16'(-$urandom_range(1, 4096));
        return 16'($urandom);
    endfunction

    // Register lanes: slopes span 0..3.0, powers 0..4.0 and offsets -0.5..0.5,
    // with an occasional fully random lane.
    function automatic logic [15:0] rand_lane(int kind);
        if ($urandom_range(0, 7) == 0) return 16'($urandom);
        case (kind)
            0:       return 16'($urandom_range(0, 12288));
            1:       return 16'($signed($urandom_range(0, 4096)) - 2048);
            default: return 16'($urandom_range(0, 16384));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_triple(int kind);
        return {rand_lane(kind), rand_lane(kind), rand_lane(kind)};
    endfunction

    initial begin
        logic [15:0] dir_vals [10];
        start          = 1'b0;
        i_red_in       = '0;
        i_green_in     = '0;
        i_blue_in      = '0;
        i_frame_end_in = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        i_rst_n        = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed pixels at the reset setting: zero, one, the field extremes,
        // a small negative and a value of a single Q.12 step.
        dir_vals = '{16'h0000, 16'h1000, 16'h7FFF, 16'h8000, 16'hFFFF,
                     16'h0001, 16'h0800, 16'h2000, 16'h0FFF, 16'h5555};
        foreach (dir_vals[i])
            send_pixel(dir_vals[i], dir_vals[(i + 3) % 10], dir_vals[(i + 7) % 10], i[0]);
        start <= 1'b0;
        drain_pipe();

        // Extremes: zero power (0^0 = 1 included), zero slope, full-scale slope,
        // most negative and most positive offsets, maximum power, and a dropped
        // write to the unused index.
        write_all(48'h0000_FFFF_1000, 48'h8000_7FFF_8000, 48'h0000_FFFF_0001);
        write_reg(CFG_UNUSED, 48'hFFFF_FFFF_FFFF);
        foreach (dir_vals[i])
            send_pixel(dir_vals[i], dir_vals[9 - i], dir_vals[(i + 5) % 10], ~i[0]);
        start <= 1'b0;
        drain_pipe();

        // Random phases, each with a fresh register set. Phase two runs with
        // no idling at all; phase four pauses mid-way until the pipe is empty.
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 7) write_all(48'hFFFF_FFFF_FFFF, 48'h7FFF_7FFF_7FFF, 48'h0001_0001_0001);
            else write_all(rand_triple(0), rand_triple(1), rand_triple(2));
            if (ph == 5) write_reg(CFG_UNUSED, 48'($urandom));
            for (int n = 0; n < 85; n++) begin
                maybe_idle(ph != 2);
                if (ph == 4 && n == 40) begin
                    start <= 1'b0;
                    drain_pipe();
                end
                send_pixel(rand_sample(), rand_sample(), rand_sample(),
                           $urandom_range(0, 15) == 0);
            end
            start <= 1'b0;
            drain_pipe();
        end

        repeat (PIPE_DEPTH + 4) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("asc_cdl_color_grade test passed");
        end else begin
            $display("asc_cdl_color_grade test failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/asc_cdl_pkg.sv
rtl/core/asc_cdl_channel.sv
rtl/core/asc_cdl_color_grade.sv
test/asc_cdl_color_grade_checker.sv
test/asc_cdl_color_grade_tb.sv
